// File: rtl/core/gbte_pkg.sv
// shared types and constants for the gap buffer text editor
`timescale 1ns / 1ps

package gbte_pkg;

    // field widths of the stream beats
    localparam int KIND_W   = 3;
    localparam int CHAR_W   = 8;
    localparam int POS_W    = 8;
    localparam int STATUS_W = 2;
    localparam int OUT_CNT_W = 9;

    // widths of the packed stream words
    localparam int S_DATA_W = 16;
    localparam int S_USER_W = 8;
    localparam int M_DATA_W = 32;

    // command kinds as they arrive on the input stream
    localparam logic [KIND_W-1:0] KIND_FWD    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_BACK   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_START  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_END    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_INSERT = 3'd4;
    localparam logic [KIND_W-1:0] KIND_DELETE = 3'd5;
    localparam logic [KIND_W-1:0] KIND_READ   = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE  = 3'd7;

    // decoded operation handed from the front to the back
    typedef enum logic [2:0] {
        OP_FWD,
        OP_BACK,
        OP_START,
        OP_END,
        OP_INSERT,
        OP_DELETE,
        OP_READ,
        OP_NOP
    } op_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_DONE    = 2'd0,
        ST_NOTHING = 2'd1,
        ST_FULL    = 2'd2,
        ST_RANGE   = 2'd3
    } status_t;

    // back end sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_MOVE,
        S_READ
    } state_t;

    // one queued command
    typedef struct packed {
        op_t              op;
        logic [CHAR_W-1:0] char_in;
        logic [POS_W-1:0]  read_position;
    } cmd_t;

endpackage

// File: rtl/core/gbte_front.sv
// front end: accepts input beats, decodes the kind and queues commands
`timescale 1ns / 1ps

module gbte_front
    import gbte_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // char_in [7:0], read_position [15:8]
    input  logic [S_USER_W-1:0] s_tuser,   // kind [2:0], zero [7:3]
    output logic                cmd_valid,
    output cmd_t                cmd,
    input  logic                cmd_pop
);

    localparam int DEPTH = 2;

    cmd_t       q_reg [DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    cmd_t       dec_cmd;

    // classify the incoming kind
    always_comb
    begin
        dec_cmd.char_in       = s_tdata[CHAR_W-1:0];
        dec_cmd.read_position = s_tdata[CHAR_W+POS_W-1:CHAR_W];
        unique case (s_tuser[KIND_W-1:0])
            KIND_FWD:    dec_cmd.op = OP_FWD;
            KIND_BACK:   dec_cmd.op = OP_BACK;
            KIND_START:  dec_cmd.op = OP_START;
            KIND_END:    dec_cmd.op = OP_END;
            KIND_INSERT: dec_cmd.op = OP_INSERT;
            KIND_DELETE: dec_cmd.op = OP_DELETE;
            KIND_READ:   dec_cmd.op = OP_READ;
            KIND_SPARE:  dec_cmd.op = OP_NOP;
            default:     dec_cmd.op = OP_NOP;
        endcase
    end

    // queue handshake
    assign s_tready  = (count_reg != 2'(DEPTH));
    assign push      = s_tvalid && s_tready;
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = ~wr_ptr_reg;
        end
        if (cmd_pop)
        begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (push && !cmd_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && cmd_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= dec_cmd;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'(DEPTH))
        else $error("command queue over depth");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !cmd_pop) |=> count_reg == $past(count_reg) + 2'd1)
        else $error("queue count missed a push");

    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> count_reg != 2'd0)
        else $error("pop from empty command queue");
`endif

endmodule

// File: rtl/core/gbte_back.sv
// back end: gap buffer store, cursor counters and result register
`timescale 1ns / 1ps

module gbte_back
    import gbte_pkg::*;
#(
    parameter int CAPACITY = 256
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  cmd_t                cmd,
    output logic                cmd_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [XW-1:0] CAP_X = XW'(CAPACITY);

    logic [CHAR_W-1:0] text_mem [CAPACITY];
    logic [CHAR_W-1:0] mem_rdata_reg;

    state_t          state_reg, state_next;
    logic [CW-1:0]   before_reg, before_next;
    logic [CW-1:0]   after_reg, after_next;
    logic            fwd_reg, fwd_next;
    logic            jump_reg, jump_next;

    logic                 out_valid_reg;
    status_t              out_status_reg;
    logic [CHAR_W-1:0]    out_char_reg;
    logic [OUT_CNT_W-1:0] out_cursor_reg;
    logic [OUT_CNT_W-1:0] out_len_reg;

    logic              rd_en, wr_en, load_out, more;
    logic [AW-1:0]     rd_addr, wr_addr;
    logic [CHAR_W-1:0] wr_data, res_char;
    status_t           res_status;
    logic              out_free;
    logic [CW-1:0]     total;
    logic [XW-1:0]     pos_x, before_x, after_x, rd_after_x;

    assign out_free   = !out_valid_reg || m_tready;
    assign total      = before_reg + after_reg;
    assign pos_x      = XW'(cmd.read_position);
    assign before_x   = XW'(before_reg);
    assign after_x    = XW'(after_reg);
    assign rd_after_x = CAP_X - after_x + (pos_x - before_x);

    // sequencer: at most one memory read and one write per cycle
    always_comb
    begin
        state_next = state_reg;
        before_next = before_reg;
        after_next = after_reg;
        fwd_next = fwd_reg;
        jump_next = jump_reg;
        rd_en = 1'b0;
        rd_addr = '0;
        wr_en = 1'b0;
        wr_addr = '0;
        wr_data = mem_rdata_reg;
        load_out = 1'b0;
        res_status = ST_NOTHING;
        res_char = '0;
        cmd_pop = 1'b0;
        more = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    cmd_pop = 1'b1;
                    unique case (cmd.op) inside
                        OP_FWD, OP_END:
                        begin
                            if (after_reg == '0)
                            begin
                                load_out = 1'b1;
                            end
                            else
                            begin
                                rd_en = 1'b1;
                                rd_addr = AW'(CAP_C - after_reg);
                                fwd_next = 1'b1;
                                jump_next = (cmd.op == OP_END);
                                state_next = S_MOVE;
                            end
                        end
                        OP_BACK, OP_START:
                        begin
                            if (before_reg == '0)
                            begin
                                load_out = 1'b1;
                            end
                            else
                            begin
                                rd_en = 1'b1;
                                rd_addr = AW'(before_reg - CW'(1));
                                fwd_next = 1'b0;
                                jump_next = (cmd.op == OP_START);
                                state_next = S_MOVE;
                            end
                        end
                        OP_INSERT:
                        begin
                            load_out = 1'b1;
                            if (total == CAP_C)
                            begin
                                res_status = ST_FULL;
                            end
                            else
                            begin
                                wr_en = 1'b1;
                                wr_addr = AW'(before_reg);
                                wr_data = cmd.char_in;
                                before_next = before_reg + CW'(1);
                                res_status = ST_DONE;
                            end
                        end
                        OP_DELETE:
                        begin
                            load_out = 1'b1;
                            if (after_reg != '0)
                            begin
                                after_next = after_reg - CW'(1);
                                res_status = ST_DONE;
                            end
                        end
                        OP_READ:
                        begin
                            if (pos_x >= XW'(total))
                            begin
                                load_out = 1'b1;
                                res_status = ST_RANGE;
                            end
                            else
                            begin
                                rd_en = 1'b1;
                                rd_addr = (pos_x < before_x) ? AW'(pos_x) : AW'(rd_after_x);
                                state_next = S_READ;
                            end
                        end
                        OP_NOP:
                        begin
                            load_out = 1'b1;
                        end
                    endcase
                end
            end
            S_MOVE:
            begin
                // write the byte read last cycle across the gap
                wr_en = 1'b1;
                if (fwd_reg)
                begin
                    wr_addr = AW'(before_reg);
                    before_next = before_reg + CW'(1);
                    after_next = after_reg - CW'(1);
                    more = (after_reg != CW'(1));
                end
                else
                begin
                    wr_addr = AW'(CAP_C - after_reg - CW'(1));
                    before_next = before_reg - CW'(1);
                    after_next = after_reg + CW'(1);
                    more = (before_reg != CW'(1));
                end
                if (jump_reg && more)
                begin
                    rd_en = 1'b1;
                    rd_addr = fwd_reg ? AW'(CAP_C - after_next) : AW'(before_next - CW'(1));
                end
                else
                begin
                    load_out = 1'b1;
                    res_status = ST_DONE;
                    state_next = S_IDLE;
                end
            end
            S_READ:
            begin
                load_out = 1'b1;
                res_status = ST_DONE;
                res_char = mem_rdata_reg;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            before_reg <= '0;
            after_reg <= '0;
            fwd_reg <= 1'b0;
            jump_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            before_reg <= before_next;
            after_reg <= after_next;
            fwd_reg <= fwd_next;
            jump_reg <= jump_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_status_reg <= res_status;
            out_char_reg <= res_char;
            out_cursor_reg <= OUT_CNT_W'(before_next);
            out_len_reg <= OUT_CNT_W'(before_next + after_next);
        end
    end

    // text store
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            text_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            mem_rdata_reg <= text_mem[rd_addr];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_len_reg, out_cursor_reg, out_char_reg, out_status_reg};

`ifndef SYNTH
    a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (before_reg + after_reg) <= CAP_C)
        else $error("text length over capacity");

    a_move_keeps_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MOVE) |=> (before_reg + after_reg) == $past(before_reg + after_reg))
        else $error("cursor move changed text length");

    a_pop_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> out_free)
        else $error("command taken while result slot busy");

    a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && res_status == ST_FULL) |=> out_len_reg == OUT_CNT_W'(CAPACITY))
        else $error("store full flagged below capacity");
`endif

endmodule

// File: rtl/core/gap_buffer_text_editor.sv
// Gap buffer line editor with a cursor, built as a command front end and an executing back end.
// Input channel s_*: one beat is one command; kind travels in s_tuser, the insert byte and
// the read position in s_tdata. Output channel m_*: exactly one result beat per command,
// carrying status, read byte, cursor position and text length, in command order.
// The front end holds a two-entry command queue, so new commands are taken while a
// result waits on m_tready; a stalled receiver only fills that queue and then s_tready drops.
// Each command first waits in the queue register; moves at an empty side, insert, delete and
// no-op commands then load the result register directly, while a single step and a read pass
// through S_MOVE or S_READ first; a jump to start or end repeats S_MOVE for each character it
// carries across the gap. Rate: one command per cycle for insert, delete and no-op while
// m_tready keeps the result slot free; a step, read or jump is finished before the next command
// is taken, as the single port pair of the text store gives one byte read and one written per cycle.
// Reset clears the cursor and length counters, the queue pointers and fill count and the result valid flag;
// the text store itself is not cleared, and only text that was written is ever read.
`timescale 1ns / 1ps

module gap_buffer_text_editor
    import gbte_pkg::*;
#(
    parameter int CAPACITY = 256
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // char_in [7:0], read_position [15:8]
    input  logic [S_USER_W-1:0] s_tuser,   // kind [2:0], zero [7:3]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // status [1:0], char_out [9:2],
                                           // cursor_position [18:10], text_length [27:19]
);

    logic cmd_valid;
    logic cmd_pop;
    cmd_t cmd;

    // command intake and queue
    gbte_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    // command execution and results
    gbte_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule
